/* design/ced_pkg.sv */
package ced_pkg;

  localparam int RQ_DEPTH = 8;

  localparam logic [1:0] CFG_WIN_START = 2'd0;
  localparam logic [1:0] CFG_WIN_END   = 2'd1;
  localparam logic [1:0] CFG_TIE_TOL   = 2'd2;

  typedef enum logic [1:0] {
    SLOPE_NONE = 2'd0,
    SLOPE_POS  = 2'd1,
    SLOPE_NEG  = 2'd2,
    SLOPE_ZERO = 2'd3
  } slope_t;

  typedef enum logic [1:0] {
    KIND_LMAX = 2'd0,
    KIND_LMIN = 2'd1,
    KIND_GMAX = 2'd2,
    KIND_GMIN = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [15:0] y;
    logic [15:0]        x;
    logic [11:0]        ties;
  } best_t;

  typedef struct packed {
    kind_t              kind;
    logic [15:0]        point_x;
    logic signed [15:0] point_y;
    logic [11:0]        tie_count;
    logic               end_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0]       num;
    result_t [2:0]    res;
  } push_t;

endpackage

/* design/ced_core.sv */
module ced_core #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,
  input  logic                in_tlast,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_addr,
  input  logic [15:0]         cfg_wdata,
  input  logic                room,
  output ced_pkg::push_t      push
);
  import ced_pkg::*;

  localparam int HALF_SAMPLES = MAX_SAMPLES / 2;
  localparam logic [11:0] TIE_LIMIT = (HALF_SAMPLES > 4095) ? 12'd4095 : 12'(HALF_SAMPLES);

  logic [15:0]        win_start_r;
  logic [15:0]        win_end_r;
  logic [15:0]        tie_tol_r;

  logic               hold_vld_r;
  logic [15:0]        hold_x_r;
  logic signed [15:0] hold_y_r;
  logic               hold_last_r;

  logic [15:0]        prev_x_r;
  logic signed [15:0] prev_y_r;
  slope_t             prev_slope_r;
  logic [1:0]         seen_r;
  best_t              max_r;
  best_t              min_r;

  logic               proc_go;
  logic signed [16:0] dy;
  slope_t             slope;
  logic               is_peak;
  logic               is_valley;
  logic               in_win;
  logic               loc_v;
  best_t              max_nxt;
  best_t              min_nxt;
  result_t            loc_res;
  result_t            gmax_res;
  result_t            gmin_res;

  function automatic best_t track_best(input best_t b, input logic is_min,
                                       input logic [15:0] x, input logic signed [15:0] y,
                                       input logic [15:0] tol);
    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic               better;
    best_t              r;
    begin
      r      = b;
      diff   = $signed({b.y[15], b.y}) - $signed({y[15], y});
      mag    = diff[16] ? 17'(-diff) : 17'(diff);
      better = is_min ? (y < b.y) : (y > b.y);
      if (b.ties == 12'd0) begin
        r.y    = y;
        r.x    = x;
        r.ties = 12'd1;
      end else if (mag < {1'b0, tol}) begin
        if (b.ties < TIE_LIMIT) begin
          r.ties = b.ties + 12'd1;
        end
      end else if (better) begin
        r.y    = y;
        r.x    = x;
        r.ties = 12'd1;
      end
      return r;
    end
  endfunction

  assign proc_go   = hold_vld_r && room;
  assign in_tready = !hold_vld_r || room;

  always_comb begin
    dy        = $signed({hold_y_r[15], hold_y_r}) - $signed({prev_y_r[15], prev_y_r});
    slope     = (dy == 17'sd0) ? SLOPE_ZERO : (dy[16] ? SLOPE_NEG : SLOPE_POS);
    is_peak   = (seen_r == 2'd2) && (prev_slope_r == SLOPE_POS) && (slope != SLOPE_POS);
    is_valley = (seen_r == 2'd2) && (prev_slope_r == SLOPE_NEG) && (slope != SLOPE_NEG);
    in_win    = (prev_x_r >= win_start_r) && (prev_x_r <= win_end_r);
    loc_v     = (is_peak || is_valley) && in_win;
    max_nxt   = is_peak ? track_best(max_r, 1'b0, prev_x_r, prev_y_r, tie_tol_r) : max_r;
    min_nxt   = is_valley ? track_best(min_r, 1'b1, prev_x_r, prev_y_r, tie_tol_r) : min_r;

    loc_res.kind       = is_peak ? KIND_LMAX : KIND_LMIN;
    loc_res.point_x    = prev_x_r;
    loc_res.point_y    = prev_y_r;
    loc_res.tie_count  = 12'd0;
    loc_res.end_of_run = !hold_last_r;

    gmax_res.kind       = KIND_GMAX;
    gmax_res.point_x    = max_nxt.x;
    gmax_res.point_y    = max_nxt.y;
    gmax_res.tie_count  = max_nxt.ties;
    gmax_res.end_of_run = 1'b0;

    gmin_res.kind       = KIND_GMIN;
    gmin_res.point_x    = min_nxt.x;
    gmin_res.point_y    = min_nxt.y;
    gmin_res.tie_count  = min_nxt.ties;
    gmin_res.end_of_run = 1'b1;

    if (loc_v) begin
      push.res[0] = loc_res;
      push.res[1] = gmax_res;
      push.res[2] = gmin_res;
    end else begin
      push.res[0] = gmax_res;
      push.res[1] = gmin_res;
      push.res[2] = gmin_res;
    end
    push.num = proc_go ? ({hold_last_r, 1'b0} | {1'b0, loc_v}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= 16'd0;
      win_end_r   <= 16'hFFFF;
      tie_tol_r   <= 16'd1;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_WIN_START: win_start_r <= cfg_wdata;
        CFG_WIN_END:   win_end_r   <= cfg_wdata;
        CFG_TIE_TOL:   tie_tol_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (in_tready) begin
      hold_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_x_r    <= in_tdata[15:0];
      hold_y_r    <= in_tdata[31:16];
      hold_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r     <= 16'd0;
      prev_y_r     <= 16'sd0;
      prev_slope_r <= SLOPE_NONE;
      seen_r       <= 2'd0;
      max_r        <= '0;
      min_r        <= '0;
    end else if (proc_go) begin
      if (hold_last_r) begin
        prev_x_r     <= 16'd0;
        prev_y_r     <= 16'sd0;
        prev_slope_r <= SLOPE_NONE;
        seen_r       <= 2'd0;
        max_r        <= '0;
        min_r        <= '0;
      end else begin
        prev_x_r <= hold_x_r;
        prev_y_r <= hold_y_r;
        if (seen_r != 2'd0) begin
          prev_slope_r <= slope;
        end
        if (seen_r != 2'd2) begin
          seen_r <= seen_r + 2'd1;
        end
        max_r <= max_nxt;
        min_r <= min_nxt;
      end
    end
  end

endmodule

/* design/ced_fifo.sv */
module ced_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  ced_pkg::push_t    push,
  output logic              room,
  output logic              out_tvalid,
  input  logic              out_tready,
  output ced_pkg::result_t  out_res
);
  import ced_pkg::*;

  localparam int AW = $clog2(RQ_DEPTH);
  localparam int CW = $clog2(RQ_DEPTH + 1);

  result_t         mem_r [RQ_DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            pop;
  logic [CW-1:0]   count_nxt;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (count_r != '0);
  assign out_res    = mem_r[rd_ptr_r];
  assign room       = (count_r <= CW'(RQ_DEPTH - 3));
  assign count_nxt  = count_r + CW'(push.num) - CW'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push.num) begin
        mem_r[wr_ptr_r + AW'(i)] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + AW'(push.num);
      rd_ptr_r <= rd_ptr_r + AW'(pop);
      count_r  <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(RQ_DEPTH))
    else $error("Result queue count exceeds its depth.");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.num != 2'd0) |-> room)
    else $error("Results pushed without room for a full set.");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> count_r == $past(count_r) + CW'($past(push.num)) - CW'($past(pop)))
    else $error("Result queue count does not follow pushes and pops.");

  a_eor_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push.num != 2'd0) |-> push.res[push.num - 2'd1].end_of_run)
    else $error("Last result of an item is not marked end of run.");
`endif

endmodule

/* design/curve_extremum_detector_top.sv */
// Channel  Direction  tdata                                    tuser  tlast
// in_      slave      [15:0] sample_x, [31:16] sample_y         -      last_sample
// out_     master     [15:0] point_x, [31:16] point_y,          kind   end_of_run
//                     [43:32] tie_count, [47:44] zero
// cfg_     write      cfg_addr 0 window_start_x, 1 window_end_x, 2 tie_tolerance
//
// One sample is taken every cycle while results drain as fast as they are made.
// A sample passes an input register, then combinational slope and tracking logic
// writes its zero to three results into an eight-beat result queue. The queue drains
// one beat per cycle while out_tready is high, so a last sample, which adds two beats
// or three with a local extremum, costs extra cycles; in_tready drops while the held
// sample waits for three free slots. Reset is synchronous and active low; it empties
// the queue, clears the curve state and restores the register defaults.
module curve_extremum_detector_top #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // sample_x, sample_y
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // point_x, point_y, tie_count, zero pad
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import ced_pkg::*;

  push_t   push;
  logic    room;
  result_t out_res;

  ced_core #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .room      (room),
    .push      (push)
  );

  ced_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {4'b0000, out_res.tie_count, out_res.point_y, out_res.point_x};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.end_of_run;

endmodule
